### sv/bgua_pkg.sv
// shared constants, types and codes of the bilinear grid upscale accumulate unit
`default_nettype none
package bgua_pkg;

  localparam int GRID_W     = 48;
  localparam int GRID_H     = 36;
  localparam int GRID_WORDS = GRID_W * GRID_H * 3;
  localparam int ROW_WORDS  = GRID_W * 3;
  localparam int ADDR_W     = $clog2(GRID_WORDS);
  localparam int XI_W       = $clog2(GRID_W);
  localparam int YI_W       = $clog2(GRID_H);

  localparam int COLOR_W = 16;
  localparam int FRAC_W  = 12;
  localparam int STEP_W  = 24;
  localparam int COORD_W = 12;
  localparam int SIZE_W  = 12;
  localparam int GIDX_W  = 13;
  // (2*p+1) * step, full width
  localparam int POS_W     = COORD_W + 1 + STEP_W;
  // integer cell part of the position after the halving shift
  localparam int CELLPOS_W = POS_W - 17;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 3 * COLOR_W;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int DIV_CNT_W  = $clog2(STEP_W + 1);

  localparam int RST_OUT_WIDTH  = 640;
  localparam int RST_OUT_HEIGHT = 480;
  localparam logic [STEP_W-1:0] DIVIDEND_H = STEP_W'((GRID_W - 1) << 16);
  localparam logic [STEP_W-1:0] DIVIDEND_V = STEP_W'((GRID_H - 1) << 16);
  localparam logic [STEP_W-1:0] RST_STEP_H = STEP_W'(((GRID_W - 1) << 16) / RST_OUT_WIDTH);
  localparam logic [STEP_W-1:0] RST_STEP_V = STEP_W'(((GRID_H - 1) << 16) / RST_OUT_HEIGHT);

  // configuration register indexes
  localparam logic REG_OUT_WIDTH  = 1'b0;
  localparam logic REG_OUT_HEIGHT = 1'b1;

  // request kinds
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // red in the lowest bits
  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [STEP_W-1:0] horiz;
    logic [STEP_W-1:0] vert;
    logic              busy;
  } step_status_t;

endpackage
`default_nettype wire

### sv/bgua_ram.sv
// generic single write, dual read ram with registered read data
`default_nettype none
module bgua_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

### sv/bgua_step_div.sv
// size register writes and the bit serial divider that derives the grid steps
`default_nettype none
module bgua_step_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic                      cfg_index,
  input  wire logic [bgua_pkg::SIZE_W-1:0] cfg_data,
  output bgua_pkg::step_status_t         status
);
  import bgua_pkg::*;

  logic                 busy;
  logic                 target;
  logic [SIZE_W-1:0]    divisor;
  logic [SIZE_W-1:0]    rem;
  logic [STEP_W-1:0]    quot;
  logic [DIV_CNT_W-1:0] count;
  logic [STEP_W-1:0]    step_h;
  logic [STEP_W-1:0]    step_v;

  logic [SIZE_W:0]      trial;
  logic [SIZE_W:0]      diff;
  logic                 qbit;
  logic [SIZE_W-1:0]    rem_next;
  logic [STEP_W-1:0]    quot_next;
  logic                 start;

  assign cfg_ready = !busy;
  assign start     = cfg_valid && !busy;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial     = {rem, quot[STEP_W-1]};
    diff      = trial - {1'b0, divisor};
    qbit      = (trial >= {1'b0, divisor});
    rem_next  = qbit ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
    quot_next = {quot[STEP_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      step_h <= RST_STEP_H;
      step_v <= RST_STEP_V;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && count == DIV_CNT_W'(1)) begin
      busy <= 1'b0;
      unique case (target)
        REG_OUT_WIDTH:  step_h <= quot_next;
        REG_OUT_HEIGHT: step_v <= quot_next;
        default:        step_h <= quot_next;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      target  <= cfg_index;
      // a zero size divides as one
      divisor <= (cfg_data == '0) ? SIZE_W'(1) : cfg_data;
      rem     <= '0;
      quot    <= (cfg_index == REG_OUT_WIDTH) ? DIVIDEND_H : DIVIDEND_V;
      count   <= DIV_CNT_W'(STEP_W);
    end else if (busy) begin
      rem   <= rem_next;
      quot  <= quot_next;
      count <= count - DIV_CNT_W'(1);
    end
  end

  assign status.horiz = step_h;
  assign status.vert  = step_v;
  assign status.busy  = busy;

endmodule
`default_nettype wire

### sv/bgua_datapath.sv
// grid store and the locate, read, blend and accumulate pipeline
`default_nettype none
module bgua_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         func,
  input  wire logic [bgua_pkg::GIDX_W-1:0]  grid_index,
  input  wire logic [bgua_pkg::COLOR_W-1:0] grid_value,
  input  wire logic [bgua_pkg::COORD_W-1:0] pixel_x,
  input  wire logic [bgua_pkg::COORD_W-1:0] pixel_y,
  input  bgua_pkg::rgb_t                    acc,
  input  bgua_pkg::step_status_t            status,
  output logic                              res_valid,
  output bgua_pkg::rgb_t                    res
);
  import bgua_pkg::*;

  // stage 1: request registered
  logic               s1_valid;
  logic               s1_func;
  logic [GIDX_W-1:0]  s1_index;
  logic [COLOR_W-1:0] s1_value;
  logic [COORD_W-1:0] s1_px;
  logic [COORD_W-1:0] s1_py;
  rgb_t               s1_acc;

  // stage 2: grid positions
  logic               s2_valid;
  logic               s2_func;
  logic [GIDX_W-1:0]  s2_index;
  logic [COLOR_W-1:0] s2_value;
  logic [POS_W-1:0]   s2_pos_x;
  logic [POS_W-1:0]   s2_pos_y;
  rgb_t               s2_acc;

  // stage 3: cell and fraction, memory access
  logic               s3_valid;
  logic               s3_func;
  logic [GIDX_W-1:0]  s3_index;
  logic [COLOR_W-1:0] s3_value;
  logic [XI_W-1:0]    s3_ix;
  logic [YI_W-1:0]    s3_iy;
  logic [FRAC_W-1:0]  s3_ux;
  logic [FRAC_W-1:0]  s3_uy;
  rgb_t               s3_acc;

  // stage 4: corners read, row blend
  logic               s4_valid;
  logic [FRAC_W-1:0]  s4_ux;
  logic [FRAC_W-1:0]  s4_uy;
  rgb_t               s4_acc;

  // stage 5: column blend
  logic               s5_valid;
  logic [FRAC_W-1:0]  s5_uy;
  rgb_t               s5_acc;

  // stage 6: accumulate
  logic               s6_valid;
  rgb_t               s6_acc;

  logic [CELLPOS_W-1:0] cell_x;
  logic [CELLPOS_W-1:0] cell_y;
  logic [XI_W-1:0]      ix;
  logic [YI_W-1:0]      iy;
  logic [FRAC_W-1:0]    ux;
  logic [FRAC_W-1:0]    uy;

  logic [ADDR_W-1:0]    base0;
  logic [ADDR_W-1:0]    base1;
  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [OUT_DATA_W-1:0] res_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid && (s3_func == FUNC_PIXEL);
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_func  <= func;
    s1_index <= grid_index;
    s1_value <= grid_value;
    s1_px    <= pixel_x;
    s1_py    <= pixel_y;
    s1_acc   <= acc;

    s2_func  <= s1_func;
    s2_index <= s1_index;
    s2_value <= s1_value;
    s2_pos_x <= POS_W'({s1_px, 1'b1}) * POS_W'(status.horiz);
    s2_pos_y <= POS_W'({s1_py, 1'b1}) * POS_W'(status.vert);
    s2_acc   <= s1_acc;

    s3_func  <= s2_func;
    s3_index <= s2_index;
    s3_value <= s2_value;
    s3_ix    <= ix;
    s3_iy    <= iy;
    s3_ux    <= ux;
    s3_uy    <= uy;
    s3_acc   <= s2_acc;

    s4_ux    <= s3_ux;
    s4_uy    <= s3_uy;
    s4_acc   <= s3_acc;

    s5_uy    <= s4_uy;
    s5_acc   <= s4_acc;

    s6_acc   <= s5_acc;
  end

  // cell = position >> 17 (halving plus 16 fraction bits); past the last cell it clamps
  always_comb begin
    cell_x = s2_pos_x[POS_W-1:17];
    cell_y = s2_pos_y[POS_W-1:17];
    if (cell_x > CELLPOS_W'(GRID_W - 2)) begin
      ix = XI_W'(GRID_W - 2);
      ux = '1;
    end else begin
      ix = cell_x[XI_W-1:0];
      ux = s2_pos_x[16:5];
    end
    if (cell_y > CELLPOS_W'(GRID_H - 2)) begin
      iy = YI_W'(GRID_H - 2);
      uy = '1;
    end else begin
      iy = cell_y[YI_W-1:0];
      uy = s2_pos_y[16:5];
    end
  end

  // loads write in the same stage that pixels read, so request order is kept
  assign base0 = (ADDR_W'(s3_iy) * ADDR_W'(GRID_W) + ADDR_W'(s3_ix)) * ADDR_W'(3);
  assign base1 = base0 + ADDR_W'(ROW_WORDS);
  assign we    = s3_valid && (s3_func == FUNC_LOAD) && (int'(s3_index) < GRID_WORDS);
  assign waddr = ADDR_W'(s3_index);

  for (genvar gc = 0; gc < 3; gc++) begin : g_ch
    logic [COLOR_W-1:0]  p00;
    logic [COLOR_W-1:0]  p01;
    logic [COLOR_W-1:0]  p10;
    logic [COLOR_W-1:0]  p11;
    logic signed [16:0]  dx0;
    logic signed [16:0]  dx1;
    logic signed [29:0]  mx0;
    logic signed [29:0]  mx1;
    logic signed [29:0]  row_a;
    logic signed [29:0]  row_b;
    logic [27:0]         s5_a;
    logic [27:0]         s5_b;
    logic signed [28:0]  dy;
    logic signed [41:0]  my;
    logic signed [41:0]  col;
    logic [COLOR_W-1:0]  s6_v;
    logic [COLOR_W:0]    sum;

    // each copy holds the whole store; one copy per channel and corner row
    bgua_ram #(.WIDTH(COLOR_W), .DEPTH(GRID_WORDS)) u_row0 (
      .clk     (clk),
      .we      (we),
      .waddr   (waddr),
      .wdata   (s3_value),
      .raddr_a (base0 + ADDR_W'(gc)),
      .raddr_b (base0 + ADDR_W'(gc + 3)),
      .rdata_a (p00),
      .rdata_b (p01)
    );

    bgua_ram #(.WIDTH(COLOR_W), .DEPTH(GRID_WORDS)) u_row1 (
      .clk     (clk),
      .we      (we),
      .waddr   (waddr),
      .wdata   (s3_value),
      .raddr_a (base1 + ADDR_W'(gc)),
      .raddr_b (base1 + ADDR_W'(gc + 3)),
      .rdata_a (p10),
      .rdata_b (p11)
    );

    // p0*(4096-u) + p1*u == (p0 << 12) + (p1-p0)*u
    assign dx0   = $signed({1'b0, p01}) - $signed({1'b0, p00});
    assign dx1   = $signed({1'b0, p11}) - $signed({1'b0, p10});
    assign mx0   = dx0 * $signed({1'b0, s4_ux});
    assign mx1   = dx1 * $signed({1'b0, s4_ux});
    assign row_a = $signed({2'b00, p00, 12'd0}) + mx0;
    assign row_b = $signed({2'b00, p10, 12'd0}) + mx1;

    always_ff @(posedge clk) begin
      s5_a <= row_a[27:0];
      s5_b <= row_b[27:0];
    end

    assign dy  = $signed({1'b0, s5_b}) - $signed({1'b0, s5_a});
    assign my  = dy * $signed({1'b0, s5_uy});
    assign col = $signed({2'b00, s5_a, 12'd0}) + my;

    always_ff @(posedge clk) begin
      s6_v <= col[39:24];
    end

    assign sum = {1'b0, s6_v} + {1'b0, s6_acc[gc*COLOR_W +: COLOR_W]};
    assign res_word[gc*COLOR_W +: COLOR_W] = sum[COLOR_W] ? '1 : sum[COLOR_W-1:0];
  end

  assign res_valid = s6_valid;
  assign res       = res_word;

endmodule
`default_nettype wire

### sv/bgua_fifo.sv
// result queue between the pipeline and the output stream
`default_nettype none
module bgua_fifo (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  bgua_pkg::rgb_t push_data,
  input  wire logic     pop,
  output logic          valid,
  output bgua_pkg::rgb_t data
);
  import bgua_pkg::*;

  rgb_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  // pushes never meet a full queue: the input side holds back by credit
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + FIFO_CNT_W'(1);
        2'b01:   count <= count - FIFO_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign valid = (count != '0);
  assign data  = mem[rd_ptr];

endmodule
`default_nettype wire

### sv/bilinear_grid_upscale_accumulate_unit.sv
// top level of the bilinear grid upscale accumulate unit
//
// s_* stream carries requests. s_tuser selects the kind: a load writes one
// grid channel word, a pixel request returns one result on the m_* stream.
// A load gives no result. cfg_* writes the output width (index 0) or height
// (index 1); each write reruns a bit serial divider for the grid step, which
// holds cfg_ready and s_tready low until the last quotient bit is in.
// A pixel request passes six pipeline stages, one of them the registered
// read of the grid memories, and then the result queue before m_tvalid.
// One request is taken each cycle while s_tready is high; results come
// out in request order.
// An 8-entry result queue lets the pipeline run on while m_tready is low;
// s_tready drops while the divider runs or when every queue entry is
// promised to a pixel still in flight or waiting, and no result is ever dropped.
// Reset empties the pipeline and queue and restores the steps for 640x480.
// The grid memory holds no defined value until written.
`default_nettype none
module bilinear_grid_upscale_accumulate_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // grid_index, grid_value, pixel_x, pixel_y, acc_red, acc_green, acc_blue, 3 zero bits
  input  wire logic [103:0] s_tdata,
  // func
  input  wire logic [0:0]  s_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [11:0] cfg_data,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // sum_red, sum_green, sum_blue
  output logic [47:0]      m_tdata
);
  import bgua_pkg::*;

  step_status_t          status;
  rgb_t                  acc;
  rgb_t                  res;
  rgb_t                  out_data;
  logic                  res_valid;
  logic                  in_accept;
  logic                  pixel_accept;
  logic                  out_accept;
  logic [FIFO_CNT_W-1:0] reserved;

  assign in_accept    = s_tvalid && s_tready;
  assign pixel_accept = in_accept && (s_tuser[0] == FUNC_PIXEL);
  assign out_accept   = m_tvalid && m_tready;
  assign s_tready     = !status.busy && (reserved < FIFO_CNT_W'(FIFO_DEPTH));

  // queue entries promised to pixels in flight or waiting
  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else begin
      unique case ({pixel_accept, out_accept})
        2'b10:   reserved <= reserved + FIFO_CNT_W'(1);
        2'b01:   reserved <= reserved - FIFO_CNT_W'(1);
        default: reserved <= reserved;
      endcase
    end
  end

  assign acc.red   = s_tdata[68:53];
  assign acc.green = s_tdata[84:69];
  assign acc.blue  = s_tdata[100:85];

  bgua_step_div u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status)
  );

  bgua_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_accept),
    .func       (s_tuser[0]),
    .grid_index (s_tdata[12:0]),
    .grid_value (s_tdata[28:13]),
    .pixel_x    (s_tdata[40:29]),
    .pixel_y    (s_tdata[52:41]),
    .acc        (acc),
    .status     (status),
    .res_valid  (res_valid),
    .res        (res)
  );

  bgua_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (out_accept),
    .valid     (m_tvalid),
    .data      (out_data)
  );

  assign m_tdata = out_data;

endmodule
`default_nettype wire

### sv/bgua_checker.sv
// port level checks of the upscale unit and their binding to the top level
`default_nettype none
module bgua_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [0:0]  s_tuser,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata
);
  import bgua_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown right after reset");

  // a size write starts the step recompute, which blocks both inputs
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !cfg_ready && !s_tready)
    else $error("input taken during step recompute");

  // a pixel result is waiting once its request has passed the pipeline and queue
  a_pixel_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == FUNC_PIXEL) |-> ##7 m_tvalid)
    else $error("pixel result missing after pipeline latency");

endmodule

bind bilinear_grid_upscale_accumulate_unit bgua_checker u_bgua_checker (.*);
`default_nettype wire

### tb/bgua_sum_checker.sv
`timescale 1ns / 100ps
// checker that watches all three channels, predicts each pixel sum and compares
module bgua_sum_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  input  wire logic                             s_tready,
  // grid_index, grid_value, pixel_x, pixel_y, acc_red, acc_green, acc_blue, 3 zero bits
  input  wire logic [bgua_pkg::IN_DATA_W-1:0]   s_tdata,
  // func
  input  wire logic [0:0]                       s_tuser,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic                             cfg_index,
  input  wire logic [bgua_pkg::SIZE_W-1:0]      cfg_data,
  input  wire logic                             m_tvalid,
  input  wire logic                             m_tready,
  // sum_red, sum_green, sum_blue
  input  wire logic [bgua_pkg::OUT_DATA_W-1:0]  m_tdata,
  output int                                    fail_count,
  output int                                    outstanding,
  output int                                    results_checked
);
  import bgua_pkg::*;

  logic [COLOR_W-1:0] grid_model [GRID_WORDS];
  logic [STEP_W-1:0]  step_h;
  logic [STEP_W-1:0]  step_v;
  rgb_t               expected_sums [$];
  rgb_t               got_sum;
  rgb_t               want_sum;
  logic [GIDX_W-1:0]  req_index;
  string              channel_name [3] = '{"red", "green", "blue"};

  function automatic logic [STEP_W-1:0] grid_step(input int cells, input logic [SIZE_W-1:0] size);
    logic [31:0] divisor;
    divisor = (size == '0) ? 32'd1 : 32'(size);
    return STEP_W'((32'(cells - 1) << 16) / divisor);
  endfunction

  // pixel centre onto the grid, clamped to the last-but-one cell
  function automatic void map_to_cell(input logic [COORD_W-1:0] p, input logic [STEP_W-1:0] step,
                                      input int cells, output int idx, output int frac);
    logic [63:0] pos;
    logic [63:0] cell_pos;
    pos      = ((64'(p) * 64'd2 + 64'd1) * 64'(step)) >> 1;
    cell_pos = pos >> 16;
    if (cell_pos > 64'(cells - 2)) begin
      idx  = cells - 2;
      frac = (1 << FRAC_W) - 1;
    end else begin
      idx  = int'(cell_pos);
      frac = int'(pos[15:4]);
    end
  endfunction

  function automatic rgb_t predict_sums(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                                        input rgb_t acc);
    int          ix, iy, ux, uy, base;
    logic [63:0] top_row, bottom_row, blend, total;
    logic [OUT_DATA_W-1:0] acc_bits;
    logic [OUT_DATA_W-1:0] sum_bits;
    acc_bits = acc;
    map_to_cell(px, step_h, GRID_W, ix, ux);
    map_to_cell(py, step_v, GRID_H, iy, uy);
    for (int c = 0; c < 3; c++) begin
      base = (iy * GRID_W + ix) * 3 + c;
      top_row = 64'(grid_model[base]) * 64'(4096 - ux) + 64'(grid_model[base + 3]) * 64'(ux);
      bottom_row = 64'(grid_model[base + ROW_WORDS]) * 64'(4096 - ux)
                 + 64'(grid_model[base + ROW_WORDS + 3]) * 64'(ux);
      blend = (top_row * 64'(4096 - uy) + bottom_row * 64'(uy)) >> 24;
      total = blend + 64'(acc_bits[16*c +: 16]);
      sum_bits[16*c +: 16] = (total > 64'hFFFF) ? 16'hFFFF : total[15:0];
    end
    return rgb_t'(sum_bits);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_sums.delete();
      step_h = grid_step(GRID_W, SIZE_W'(RST_OUT_WIDTH));
      step_v = grid_step(GRID_H, SIZE_W'(RST_OUT_HEIGHT));
      fail_count = 0;
      results_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_OUT_WIDTH) step_h = grid_step(GRID_W, cfg_data);
        else step_v = grid_step(GRID_H, cfg_data);
      end
      // results first: a result at this edge never belongs to a request at this edge
      if (m_tvalid && m_tready) begin
        got_sum = rgb_t'(m_tdata);
        if (expected_sums.size() == 0) begin
          report_mismatch($sformatf("result %h with no pixel request waiting", m_tdata));
        end else begin
          want_sum = expected_sums.pop_front();
          for (int c = 0; c < 3; c++)
            if (got_sum[16*c +: 16] !== want_sum[16*c +: 16])
              report_mismatch($sformatf("%s sum got %h, expected %h", channel_name[c],
                                        got_sum[16*c +: 16], want_sum[16*c +: 16]));
          results_checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        req_index = s_tdata[12:0];
        if (s_tuser[0] == FUNC_LOAD) begin
          if (req_index < GIDX_W'(GRID_WORDS)) grid_model[req_index] = s_tdata[28:13];
        end else begin
          expected_sums.push_back(predict_sums(s_tdata[40:29], s_tdata[52:41],
                                               rgb_t'(s_tdata[100:53])));
        end
      end
    end
    outstanding = expected_sums.size();
  end

endmodule

### tb/bilinear_grid_upscale_accumulate_unit_tb.sv
`timescale 1ns / 100ps
// testbench top: grid loading, pixel requests under several sizes and stall mixes, verdict
module bilinear_grid_upscale_accumulate_unit_tb;
  import bgua_pkg::*;

  localparam int PHASE_ITEMS = 190;
  localparam int DRAIN_CYCLES = 16;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = 1'b0;
  logic [SIZE_W-1:0]     cfg_data = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int fail_count;
  int outstanding;
  int results_checked;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int loads_sent = 0;
  int pixels_sent = 0;
  int regs_written = 0;
  int cur_width = RST_OUT_WIDTH;
  int cur_height = RST_OUT_HEIGHT;

  bilinear_grid_upscale_accumulate_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  bgua_sum_checker sum_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .outstanding(outstanding), .results_checked(results_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99, 0) >= stall_pct);
  end

  task automatic send_request(input logic func, input logic [GIDX_W-1:0] gidx,
                              input logic [COLOR_W-1:0] gval, input logic [COORD_W-1:0] px,
                              input logic [COORD_W-1:0] py, input rgb_t acc);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {3'b000, acc.blue, acc.green, acc.red, py, px, gval, gidx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic load_word(input logic [GIDX_W-1:0] gidx, input logic [COLOR_W-1:0] gval);
    send_request(FUNC_LOAD, gidx, gval, COORD_W'($urandom), COORD_W'($urandom),
                 rgb_t'(48'({$urandom, $urandom})));
    loads_sent++;
  endtask

  task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                            input rgb_t acc);
    send_request(FUNC_PIXEL, GIDX_W'($urandom), COLOR_W'($urandom), px, py, acc);
    pixels_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // loads give no result, so allow the pipeline to empty after the last sum
  task automatic settle();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [SIZE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_OUT_WIDTH) cur_width = value;
    else cur_height = value;
    regs_written++;
  endtask

  task automatic random_request();
    int          kind;
    int          fw, fh;
    logic [COORD_W-1:0] px, py;
    rgb_t        acc;
    kind = $urandom_range(99, 0);
    fw = (cur_width == 0) ? 1 : cur_width;
    fh = (cur_height == 0) ? 1 : cur_height;
    if (kind < 3) begin
      load_word(GIDX_W'($urandom_range(8191, GRID_WORDS)), COLOR_W'($urandom));
    end else if (kind < 18) begin
      load_word(GIDX_W'($urandom_range(GRID_WORDS - 1, 0)), COLOR_W'($urandom));
    end else begin
      if ($urandom_range(99, 0) < 15) begin
        px = COORD_W'($urandom);
        py = COORD_W'($urandom);
      end else begin
        px = COORD_W'($urandom_range(fw - 1, 0));
        py = COORD_W'($urandom_range(fh - 1, 0));
      end
      acc = rgb_t'(48'({$urandom, $urandom}));
      if (kind < 26) acc = '1;
      else if (kind < 31) acc = '0;
      send_pixel(px, py, acc);
    end
  endtask

  initial begin
    int width_set  [4] = '{4095, 1, 0, 0};
    int height_set [4] = '{4095, 0, 1, 0};
    int idle_set   [4] = '{0, 59, 0, 33};
    int stall_set  [4] = '{0, 0, 59, 33};
    width_set[3]  = $urandom_range(4095, 1);
    height_set[3] = $urandom_range(4095, 1);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every grid word gets written before any pixel can read it
    for (int i = 0; i < GRID_WORDS; i++) begin
      if (i % 50 == 0) load_word(GIDX_W'(i), 16'hFFFF);
      else if (i % 50 == 1) load_word(GIDX_W'(i), 16'h0000);
      else load_word(GIDX_W'(i), COLOR_W'($urandom));
    end

    // corners, out of frame, saturation, ignored loads, read right after write
    send_pixel(12'd0, 12'd0, '0);
    send_pixel(12'd639, 12'd479, '0);
    send_pixel(12'd639, 12'd0, '1);
    send_pixel(12'd0, 12'd479, rgb_t'({16'h8000, 16'h8000, 16'h8000}));
    send_pixel(12'd4095, 12'd4095, '0);
    send_pixel(12'd4095, 12'd0, rgb_t'(48'({$urandom, $urandom})));
    send_pixel(12'd0, 12'd4095, rgb_t'(48'({$urandom, $urandom})));
    load_word(13'h1FFF, 16'hFFFF);
    load_word(GIDX_W'(GRID_WORDS), 16'h0000);
    send_pixel(12'd4095, 12'd4095, '0);
    load_word(13'd0, 16'hFFFF);
    load_word(13'd1, 16'hFFFF);
    load_word(13'd2, 16'hFFFF);
    send_pixel(12'd0, 12'd0, rgb_t'({16'h0001, 16'h0001, 16'h0001}));
    load_word(GIDX_W'(GRID_WORDS - 1), 16'h0000);
    load_word(GIDX_W'(GRID_WORDS - 1 - ROW_WORDS), 16'hFFFF);
    send_pixel(12'd4095, 12'd4095, '1);
    send_pixel(12'd320, 12'd240, rgb_t'(48'({$urandom, $urandom})));
    send_pixel(12'd1, 12'd1, '0);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_reg(REG_OUT_WIDTH, SIZE_W'(width_set[ph]));
      write_reg(REG_OUT_HEIGHT, SIZE_W'(height_set[ph]));
      send_idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_for_results();
        random_request();
      end
    end

    settle();
    $display("run covered %0d grid loads, %0d pixel requests and %0d size register writes",
             loads_sent, pixels_sent, regs_written);
    $display("%0d sums checked over default, extreme, zero and random frame sizes with stalls",
             results_checked);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
